// File: src/ibms_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// I2C bus master sequencer package
// Shared types and constants: command codes, sequence phases, divider sizes.
// ----------------------------------------------------------------------------
package ibms_pkg;

    localparam int DIVIDER_WIDTH = 8;
    localparam int HPT_WIDTH     = 8;
    localparam int CMP_WIDTH     =
        ((DIVIDER_WIDTH > HPT_WIDTH) ? DIVIDER_WIDTH : HPT_WIDTH) + 1;
    localparam logic [CMP_WIDTH-1:0] DIV_MAX =
        CMP_WIDTH'((1 << DIVIDER_WIDTH) - 1);
    localparam logic [HPT_WIDTH-1:0] HPT_RESET = HPT_WIDTH'(10);
    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

    typedef enum logic [2:0] {
        CMD_TICK  = 3'd0,
        CMD_START = 3'd1,
        CMD_STOP  = 3'd2,
        CMD_WRITE = 3'd3,
        CMD_READ  = 3'd4
    } command_t;

    typedef enum logic [3:0] {
        PH_IDLE    = 4'd0,
        PH_START_A = 4'd1,
        PH_START_B = 4'd2,
        PH_START_C = 4'd3,
        PH_STOP_A  = 4'd4,
        PH_STOP_B  = 4'd5,
        PH_STOP_C  = 4'd6,
        PH_WR_LOW  = 4'd7,
        PH_WR_HIGH = 4'd8,
        PH_WA_LOW  = 4'd9,
        PH_WA_HIGH = 4'd10,
        PH_RD_LOW  = 4'd11,
        PH_RD_HIGH = 4'd12,
        PH_RA_LOW  = 4'd13,
        PH_RA_HIGH = 4'd14
    } phase_t;

endpackage : ibms_pkg
`default_nettype wire

// File: src/i2c_bus_master_sequencer.sv
`timescale 1ns / 1ps
`default_nettype none
// An accepted s_ word passes the input register, then the result register.
// One word per clock cycle unless the result stalls; the input register can take one.
// Each word is one pass through the phase logic between the input and result registers.
// Reset (aresetn low, synchronous) idles the sequencer, releases both lines and
// restores the half period to ten ticks; both register stages are emptied.
// ----------------------------------------------------------------------------
// I2C bus master sequencer
// Single-master I2C sequencer with push-pull SCL and no clock stretching.
// ----------------------------------------------------------------------------
module i2c_bus_master_sequencer (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    // half period configuration
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [7:0] cfg_data,
    // command words
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [2:0] s_command,
    input  wire logic [7:0] s_data_byte,
    input  wire logic       s_send_ack,
    input  wire logic       s_sda_level,
    input  wire logic       s_tick,
    // result words
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic            m_scl_level,
    output logic            m_sda_released,
    output logic            m_busy_res,
    output logic            m_done_res,
    output logic [7:0]      m_received_byte,
    output logic            m_ack_seen,
    output logic            m_rejected
);

    // The configuration register is always writable; software must write it only while the
    // sequencer is idle, and the block itself does not enforce this.
    logic [ibms_pkg::HPT_WIDTH-1:0] hpt_reg;

    // Input register stage.
    logic       in_valid_reg;
    logic [2:0] cmd_reg;
    logic [7:0] data_reg;
    logic       send_ack_reg;
    logic       sda_in_reg;
    logic       tick_reg;

    // Sequencer state.
    ibms_pkg::phase_t                  phase_reg, phase_next;
    logic [3:0]                        bit_cnt_reg, bit_cnt_next;
    logic [7:0]                        shift_reg, shift_next;
    logic [ibms_pkg::DIVIDER_WIDTH-1:0] div_cnt_reg, div_cnt_next;
    logic                              scl_reg, scl_next;
    logic                              sda_reg, sda_next;
    logic                              ack_reg, ack_next;
    logic                              ack_to_send_reg, ack_to_send_next;
    logic [7:0]                        read_byte_reg, read_byte_next;

    // Result register stage.
    logic m_valid_reg;
    logic m_done_reg, m_done_next;
    logic m_rejected_reg, m_rejected_next;

    logic                              advance;
    logic                              is_cmd;
    logic [ibms_pkg::CMP_WIDTH-1:0]    div_inc;
    logic                              half_end;

    // A word moves from the input register to the result register whenever
    // the result register is empty or being emptied in the same cycle.
    assign advance   = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    assign is_cmd = cmd_reg inside {[ibms_pkg::CMD_START : ibms_pkg::CMD_READ]};

    // Half period divider: the increment is compared with the register and
    // with the divider's own maximum, so a zero register behaves like one.
    assign div_inc  = ibms_pkg::CMP_WIDTH'(div_cnt_reg) + ibms_pkg::CMP_WIDTH'(1);
    assign half_end = (div_inc >= ibms_pkg::CMP_WIDTH'(hpt_reg)) ||
                      (div_inc >= ibms_pkg::DIV_MAX);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hpt_reg <= ibms_pkg::HPT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            hpt_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            cmd_reg      <= s_command;
            data_reg     <= s_data_byte;
            send_ack_reg <= s_send_ack;
            sda_in_reg   <= s_sda_level;
            tick_reg     <= s_tick;
        end
    end

    // Next state of the sequencer for the word held in the input register.
    always_comb begin
        phase_next       = phase_reg;
        bit_cnt_next     = bit_cnt_reg;
        shift_next       = shift_reg;
        div_cnt_next     = div_cnt_reg;
        scl_next         = scl_reg;
        sda_next         = sda_reg;
        ack_next         = ack_reg;
        ack_to_send_next = ack_to_send_reg;
        read_byte_next   = read_byte_reg;
        m_done_next      = 1'b0;
        m_rejected_next  = 1'b0;

        if (phase_reg != ibms_pkg::PH_IDLE) begin
            m_rejected_next = is_cmd;
            if (tick_reg) begin
                if (half_end) begin
                    div_cnt_next = '0;
                    case (phase_reg)
                        ibms_pkg::PH_START_A: begin
                            scl_next   = 1'b1;
                            phase_next = ibms_pkg::PH_START_B;
                        end
                        ibms_pkg::PH_START_B: begin
                            sda_next   = 1'b0;
                            phase_next = ibms_pkg::PH_START_C;
                        end
                        ibms_pkg::PH_START_C: begin
                            scl_next    = 1'b0;
                            phase_next  = ibms_pkg::PH_IDLE;
                            m_done_next = 1'b1;
                        end
                        ibms_pkg::PH_STOP_A: begin
                            scl_next   = 1'b1;
                            phase_next = ibms_pkg::PH_STOP_B;
                        end
                        ibms_pkg::PH_STOP_B: begin
                            sda_next   = 1'b1;
                            phase_next = ibms_pkg::PH_STOP_C;
                        end
                        ibms_pkg::PH_WR_LOW: begin
                            scl_next   = 1'b1;
                            phase_next = ibms_pkg::PH_WR_HIGH;
                        end
                        ibms_pkg::PH_WR_HIGH: begin
                            scl_next = 1'b0;
                            if (bit_cnt_reg != 4'd0) begin
                                // Next data bit goes out on the falling edge.
                                sda_next     = shift_reg[7];
                                shift_next   = {shift_reg[6:0], 1'b0};
                                bit_cnt_next = bit_cnt_reg - 4'd1;
                                phase_next   = ibms_pkg::PH_WR_LOW;
                            end else begin
                                sda_next   = 1'b1;
                                phase_next = ibms_pkg::PH_WA_LOW;
                            end
                        end
                        ibms_pkg::PH_WA_LOW: begin
                            scl_next   = 1'b1;
                            phase_next = ibms_pkg::PH_WA_HIGH;
                        end
                        ibms_pkg::PH_WA_HIGH: begin
                            ack_next    = sda_in_reg;
                            scl_next    = 1'b0;
                            phase_next  = ibms_pkg::PH_IDLE;
                            m_done_next = 1'b1;
                        end
                        ibms_pkg::PH_RD_LOW: begin
                            scl_next   = 1'b1;
                            phase_next = ibms_pkg::PH_RD_HIGH;
                        end
                        ibms_pkg::PH_RD_HIGH: begin
                            shift_next   = {shift_reg[6:0], sda_in_reg};
                            scl_next     = 1'b0;
                            bit_cnt_next = bit_cnt_reg - 4'd1;
                            if (bit_cnt_reg != 4'd1) begin
                                phase_next = ibms_pkg::PH_RD_LOW;
                            end else begin
                                read_byte_next = {shift_reg[6:0], sda_in_reg};
                                sda_next       = !ack_to_send_reg;
                                phase_next     = ibms_pkg::PH_RA_LOW;
                            end
                        end
                        ibms_pkg::PH_RA_LOW: begin
                            scl_next   = 1'b1;
                            phase_next = ibms_pkg::PH_RA_HIGH;
                        end
                        ibms_pkg::PH_RA_HIGH: begin
                            scl_next    = 1'b0;
                            phase_next  = ibms_pkg::PH_IDLE;
                            m_done_next = 1'b1;
                        end
                        default: begin
                            // Stop's last half period simply ends the sequence.
                            phase_next  = ibms_pkg::PH_IDLE;
                            m_done_next = 1'b1;
                        end
                    endcase
                end else begin
                    div_cnt_next = div_inc[ibms_pkg::DIVIDER_WIDTH-1:0];
                end
            end
        end else if (is_cmd) begin
            div_cnt_next = '0;
            case (cmd_reg)
                ibms_pkg::CMD_START: begin
                    sda_next   = 1'b1;
                    phase_next = ibms_pkg::PH_START_A;
                end
                ibms_pkg::CMD_STOP: begin
                    sda_next   = 1'b0;
                    phase_next = ibms_pkg::PH_STOP_A;
                end
                ibms_pkg::CMD_WRITE: begin
                    // The first bit goes out at once, MSB first.
                    sda_next     = data_reg[7];
                    shift_next   = {data_reg[6:0], 1'b0};
                    bit_cnt_next = ibms_pkg::BITS_PER_BYTE - 4'd1;
                    phase_next   = ibms_pkg::PH_WR_LOW;
                end
                default: begin
                    sda_next         = 1'b1;
                    shift_next       = '0;
                    bit_cnt_next     = ibms_pkg::BITS_PER_BYTE;
                    ack_to_send_next = send_ack_reg;
                    phase_next       = ibms_pkg::PH_RD_LOW;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= ibms_pkg::PH_IDLE;
            bit_cnt_reg     <= '0;
            shift_reg       <= '0;
            div_cnt_reg     <= '0;
            scl_reg         <= 1'b1;
            sda_reg         <= 1'b1;
            ack_reg         <= 1'b0;
            ack_to_send_reg <= 1'b0;
            read_byte_reg   <= '0;
        end else if (advance) begin
            phase_reg       <= phase_next;
            bit_cnt_reg     <= bit_cnt_next;
            shift_reg       <= shift_next;
            div_cnt_reg     <= div_cnt_next;
            scl_reg         <= scl_next;
            sda_reg         <= sda_next;
            ack_reg         <= ack_next;
            ack_to_send_reg <= ack_to_send_next;
            read_byte_reg   <= read_byte_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_done_reg     <= m_done_next;
            m_rejected_reg <= m_rejected_next;
        end
    end

    // Line levels, busy and captured bytes follow the state registers, which
    // only change when a word enters the result register.
    assign m_valid         = m_valid_reg;
    assign m_scl_level     = scl_reg;
    assign m_sda_released  = sda_reg;
    assign m_busy_res      = (phase_reg != ibms_pkg::PH_IDLE);
    assign m_done_res      = m_done_reg;
    assign m_received_byte = read_byte_reg;
    assign m_ack_seen      = ack_reg;
    assign m_rejected      = m_rejected_reg;

    // An accepted command from idle always starts a sequence.
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance && (phase_reg == ibms_pkg::PH_IDLE) && is_cmd
        |=> phase_reg != ibms_pkg::PH_IDLE)
        else $error("command from idle did not start a sequence");

    // A finished sequence leaves the block idle in the same result.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_done_reg |-> !m_busy_res)
        else $error("done reported while still busy");

    // The divider never rests at its saturation value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        ibms_pkg::CMP_WIDTH'(div_cnt_reg) < ibms_pkg::DIV_MAX)
        else $error("divider count saturated");

    // Rejection is only ever reported while a sequence was running.
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance && (phase_reg == ibms_pkg::PH_IDLE) |=> !m_rejected_reg)
        else $error("command rejected while idle");

endmodule : i2c_bus_master_sequencer
`default_nettype wire

// File: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C bus master sequencer testbench
// Drives command words with random gaps, back-pressures the result side at
// random and checks every result word against a word-level predictor of the
// sequencer's line levels, status flags and received data.
// ----------------------------------------------------------------------------
module tb;

    // Command codes 5 to 7 are not defined; the sequencer treats them as ticks.
    localparam logic [2:0] CMD_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] CMD_UNUSED_LAST  = 3'd7;

    // The divider wraps at its own maximum, whatever the register says.
    localparam int DIVIDER_LIMIT = (1 << ibms_pkg::DIVIDER_WIDTH) - 1;

    // Roughly this many busy-time words per random phase.
    localparam int PHASE_WORDS = 40;

    typedef struct packed {
        logic [2:0] command;
        logic [7:0] data_byte;
        logic       send_ack;
        logic       sda_level;
        logic       tick;
    } cmd_word_t;

    typedef struct packed {
        logic       scl_level;
        logic       sda_released;
        logic       busy;
        logic       done;
        logic [7:0] received_byte;
        logic       ack_seen;
        logic       rejected;
    } line_word_t;

    logic       aclk      = 1'b0;
    logic       aresetn   = 1'b0;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [7:0] cfg_data  = '0;
    logic       s_valid   = 1'b0;
    logic       s_ready;
    logic [2:0] s_command = '0;
    logic [7:0] s_data_byte = '0;
    logic       s_send_ack  = 1'b0;
    logic       s_sda_level = 1'b0;
    logic       s_tick      = 1'b0;
    logic       m_valid;
    logic       m_ready   = 1'b0;
    logic       m_scl_level;
    logic       m_sda_released;
    logic       m_busy_res;
    logic       m_done_res;
    logic [7:0] m_received_byte;
    logic       m_ack_seen;
    logic       m_rejected;

    i2c_bus_master_sequencer i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_command       (s_command),
        .s_data_byte     (s_data_byte),
        .s_send_ack      (s_send_ack),
        .s_sda_level     (s_sda_level),
        .s_tick          (s_tick),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_scl_level     (m_scl_level),
        .m_sda_released  (m_sda_released),
        .m_busy_res      (m_busy_res),
        .m_done_res      (m_done_res),
        .m_received_byte (m_received_byte),
        .m_ack_seen      (m_ack_seen),
        .m_rejected      (m_rejected)
    );

    // Words still to be driven, and the line states they are predicted to give.
    cmd_word_t  cmd_words_pending[$];
    line_word_t line_states_due[$];

    // Predicted sequencer state. It starts at the reset values, as the block
    // is reset only once, at the very start of the run.
    logic [7:0]                         half_period = ibms_pkg::HPT_RESET;
    ibms_pkg::phase_t                   seq_phase   = ibms_pkg::PH_IDLE;
    logic [3:0]                         bits_left   = '0;
    logic [7:0]                         shifter     = '0;
    logic [ibms_pkg::DIVIDER_WIDTH-1:0] div_count   = '0;
    logic                               scl_q       = 1'b1;
    logic                               sda_q       = 1'b1;
    logic                               ack_q       = 1'b0;
    logic                               ack_send    = 1'b0;
    logic [7:0]                         last_read   = '0;

    // Idling percentages, chosen afresh for every phase of the run.
    int src_gap_pct    = 0;
    int sink_stall_pct = 0;

    int error_count    = 0;
    int words_accepted = 0;
    int busy_words     = 0;
    int settings_made  = 0;
    int refused_count  = 0;
    int starts_sent    = 0;
    int stops_sent     = 0;
    int writes_sent    = 0;
    int reads_sent     = 0;

    initial begin
        forever #10 aclk = ~aclk;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int idle_length();
        if ($urandom_range(99) < 85) begin
            return $urandom_range(3, 1);
        end
        return $urandom_range(40, 10);
    endfunction

    // Advances the predicted sequencer by one word and returns the line state
    // and flags that the word should produce.
    function automatic line_word_t step_sequencer(cmd_word_t w);
        line_word_t r;
        logic       is_cmd;
        logic       finished;
        int         next_count;
        is_cmd   = (w.command >= ibms_pkg::CMD_START) && (w.command <= ibms_pkg::CMD_READ);
        finished = 1'b0;
        r.rejected = 1'b0;
        if (seq_phase != ibms_pkg::PH_IDLE) begin
            busy_words++;
            r.rejected = is_cmd;
            if (is_cmd) begin
                refused_count++;
            end
            if (w.tick) begin
                next_count = int'(div_count) + 1;
                if (next_count >= int'(half_period) || next_count >= DIVIDER_LIMIT) begin
                    div_count = '0;
                    case (seq_phase)
                        ibms_pkg::PH_START_A: begin
                            scl_q     = 1'b1;
                            seq_phase = ibms_pkg::PH_START_B;
                        end
                        ibms_pkg::PH_START_B: begin
                            sda_q     = 1'b0;
                            seq_phase = ibms_pkg::PH_START_C;
                        end
                        ibms_pkg::PH_START_C: begin
                            scl_q    = 1'b0;
                            finished = 1'b1;
                        end
                        ibms_pkg::PH_STOP_A: begin
                            scl_q     = 1'b1;
                            seq_phase = ibms_pkg::PH_STOP_B;
                        end
                        ibms_pkg::PH_STOP_B: begin
                            sda_q     = 1'b1;
                            seq_phase = ibms_pkg::PH_STOP_C;
                        end
                        ibms_pkg::PH_WR_LOW: begin
                            scl_q     = 1'b1;
                            seq_phase = ibms_pkg::PH_WR_HIGH;
                        end
                        ibms_pkg::PH_WR_HIGH: begin
                            scl_q = 1'b0;
                            if (bits_left != 0) begin
                                sda_q     = shifter[7];
                                shifter   = shifter << 1;
                                bits_left = bits_left - 4'd1;
                                seq_phase = ibms_pkg::PH_WR_LOW;
                            end else begin
                                sda_q     = 1'b1;
                                seq_phase = ibms_pkg::PH_WA_LOW;
                            end
                        end
                        ibms_pkg::PH_WA_LOW: begin
                            scl_q     = 1'b1;
                            seq_phase = ibms_pkg::PH_WA_HIGH;
                        end
                        ibms_pkg::PH_WA_HIGH: begin
                            ack_q    = w.sda_level;
                            scl_q    = 1'b0;
                            finished = 1'b1;
                        end
                        ibms_pkg::PH_RD_LOW: begin
                            scl_q     = 1'b1;
                            seq_phase = ibms_pkg::PH_RD_HIGH;
                        end
                        ibms_pkg::PH_RD_HIGH: begin
                            shifter   = {shifter[6:0], w.sda_level};
                            scl_q     = 1'b0;
                            bits_left = bits_left - 4'd1;
                            if (bits_left != 0) begin
                                seq_phase = ibms_pkg::PH_RD_LOW;
                            end else begin
                                last_read = shifter;
                                sda_q     = ~ack_send;
                                seq_phase = ibms_pkg::PH_RA_LOW;
                            end
                        end
                        ibms_pkg::PH_RA_LOW: begin
                            scl_q     = 1'b1;
                            seq_phase = ibms_pkg::PH_RA_HIGH;
                        end
                        ibms_pkg::PH_RA_HIGH: begin
                            scl_q    = 1'b0;
                            finished = 1'b1;
                        end
                        default: begin
                            finished = 1'b1;
                        end
                    endcase
                    if (finished) begin
                        seq_phase = ibms_pkg::PH_IDLE;
                    end
                end else begin
                    div_count = ibms_pkg::DIVIDER_WIDTH'(next_count);
                end
            end
        end else if (is_cmd) begin
            busy_words++;
            div_count = '0;
            case (ibms_pkg::command_t'(w.command))
                ibms_pkg::CMD_START: begin
                    sda_q     = 1'b1;
                    seq_phase = ibms_pkg::PH_START_A;
                end
                ibms_pkg::CMD_STOP: begin
                    sda_q     = 1'b0;
                    seq_phase = ibms_pkg::PH_STOP_A;
                end
                ibms_pkg::CMD_WRITE: begin
                    // The first data bit goes out together with the command.
                    shifter   = w.data_byte << 1;
                    sda_q     = w.data_byte[7];
                    bits_left = ibms_pkg::BITS_PER_BYTE - 4'd1;
                    seq_phase = ibms_pkg::PH_WR_LOW;
                end
                default: begin
                    sda_q     = 1'b1;
                    shifter   = '0;
                    bits_left = ibms_pkg::BITS_PER_BYTE;
                    ack_send  = w.send_ack;
                    seq_phase = ibms_pkg::PH_RD_LOW;
                end
            endcase
        end
        r.scl_level     = scl_q;
        r.sda_released  = sda_q;
        r.busy          = (seq_phase != ibms_pkg::PH_IDLE);
        r.done          = finished;
        r.received_byte = last_read;
        r.ack_seen      = ack_q;
        return r;
    endfunction

    // Queues one word for the driver together with its predicted result.
    task automatic queue_word(logic [2:0] cmd, logic [7:0] data, logic ack, logic sda,
                              logic tk);
        cmd_word_t w;
        w.command   = cmd;
        w.data_byte = data;
        w.send_ack  = ack;
        w.sda_level = sda;
        w.tick      = tk;
        line_states_due.push_back(step_sequencer(w));
        cmd_words_pending.push_back(w);
    endtask

    // Feeds words until the predicted sequence has finished. A negative SDA
    // choice samples random line levels. With noise on, ticks are sometimes
    // missing and stray commands arrive, which the block must refuse or ignore.
    task automatic finish_busy(int sda_choice, bit noisy);
        logic [2:0] cmd;
        logic       sda;
        logic       tk;
        int         pick;
        while (seq_phase != ibms_pkg::PH_IDLE) begin
            pick = $urandom_range(99);
            cmd  = ibms_pkg::CMD_TICK;
            tk   = 1'b1;
            if (noisy) begin
                if (pick < 8) begin
                    cmd = 3'($urandom_range(ibms_pkg::CMD_READ, ibms_pkg::CMD_START));
                end else if (pick < 14) begin
                    cmd = 3'($urandom_range(CMD_UNUSED_LAST, CMD_UNUSED_FIRST));
                end
                tk = ($urandom_range(99) < 80);
            end
            sda = (sda_choice < 0) ? 1'($urandom_range(1)) : 1'(sda_choice);
            queue_word(cmd, 8'($urandom_range(255)), 1'($urandom_range(1)), sda, tk);
        end
    endtask

    task automatic issue_command(ibms_pkg::command_t cmd, logic [7:0] data, logic ack,
                                 int sda_choice, bit noisy);
        case (cmd)
            ibms_pkg::CMD_START: starts_sent++;
            ibms_pkg::CMD_STOP:  stops_sent++;
            ibms_pkg::CMD_WRITE: writes_sent++;
            default:             reads_sent++;
        endcase
        queue_word(cmd, data, ack, 1'($urandom_range(1)), 1'($urandom_range(1)));
        finish_busy(sda_choice, noisy);
    endtask

    // A few words the idle block should take no notice of: bare ticks, empty
    // words and undefined codes.
    task automatic idle_noise();
        int count;
        count = $urandom_range(2);
        repeat (count) begin
            queue_word($urandom_range(1) ? ibms_pkg::CMD_TICK :
                       3'($urandom_range(CMD_UNUSED_LAST, CMD_UNUSED_FIRST)),
                       8'($urandom_range(255)), 1'($urandom_range(1)),
                       1'($urandom_range(1)), 1'($urandom_range(1)));
        end
    endtask

    // Mostly a proper bus transaction (start, a few bytes, perhaps a repeated
    // start, stop); now and then a lone command out of any order.
    task automatic run_transaction();
        int bytes;
        if ($urandom_range(99) < 20) begin
            issue_command(ibms_pkg::command_t'($urandom_range(ibms_pkg::CMD_READ,
                                                              ibms_pkg::CMD_START)),
                          8'($urandom_range(255)), 1'($urandom_range(1)), -1, 1'b1);
        end else begin
            issue_command(ibms_pkg::CMD_START, 8'($urandom_range(255)), 1'b0, -1, 1'b1);
            issue_command(ibms_pkg::CMD_WRITE, 8'($urandom_range(255)), 1'b0, -1, 1'b1);
            bytes = $urandom_range(2);
            repeat (bytes) begin
                idle_noise();
                if ($urandom_range(99) < 15) begin
                    issue_command(ibms_pkg::CMD_START, 8'($urandom_range(255)), 1'b0, -1,
                                  1'b1);
                end
                issue_command($urandom_range(1) ? ibms_pkg::CMD_WRITE : ibms_pkg::CMD_READ,
                              8'($urandom_range(255)), 1'($urandom_range(1)), -1, 1'b1);
            end
            issue_command(ibms_pkg::CMD_STOP, 8'($urandom_range(255)), 1'b0, -1, 1'b1);
        end
        idle_noise();
    endtask

    // Waits until the sequencer has gone quiet, then writes the half period.
    // Every result has arrived by then, so the sender has fully paused.
    task automatic set_half_period(logic [7:0] value);
        int pick;
        while (cmd_words_pending.size() != 0 || line_states_due.size() != 0) begin
            @(posedge aclk);
        end
        repeat (4) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do begin
            @(posedge aclk);
        end while (!cfg_ready);
        cfg_valid <= 1'b0;
        half_period = value;
        settings_made++;
        pick = $urandom_range(2);
        src_gap_pct    = (pick == 0) ? 0 : (pick == 1) ? 15 : 50;
        pick = $urandom_range(2);
        sink_stall_pct = (pick == 0) ? 0 : (pick == 1) ? 15 : 50;
    endtask

    // Reports one field that differs from its prediction.
    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
            error_count++;
        end
    endfunction

    // Command driver: presents the next pending word whenever the current one
    // has been taken, leaving random gaps between words.
    always @(posedge aclk) begin : command_driver
        cmd_word_t w;
        int        idle_left;
        if (!aresetn) begin
            s_valid   <= 1'b0;
            idle_left = 0;
        end else begin
            if (s_valid && s_ready) begin
                words_accepted++;
            end
            if (!s_valid || s_ready) begin
                if (idle_left == 0 && cmd_words_pending.size() != 0) begin
                    w = cmd_words_pending.pop_front();
                    s_valid     <= 1'b1;
                    s_command   <= w.command;
                    s_data_byte <= w.data_byte;
                    s_send_ack  <= w.send_ack;
                    s_sda_level <= w.sda_level;
                    s_tick      <= w.tick;
                    idle_left = ($urandom_range(99) < src_gap_pct) ? idle_length() : 0;
                end else begin
                    s_valid <= 1'b0;
                    if (idle_left > 0) begin
                        idle_left--;
                    end
                end
            end
        end
    end

    // Result monitor: compares every accepted result word with the oldest
    // prediction, and stalls the result side at random.
    always @(posedge aclk) begin : result_monitor
        line_word_t want;
        int         stall_left;
        if (!aresetn) begin
            m_ready    <= 1'b0;
            stall_left = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (line_states_due.size() == 0) begin
                    $display("%0t ns: result word arrived with no prediction waiting", $time);
                    error_count++;
                end else begin
                    want = line_states_due.pop_front();
                    check_field("scl_level", want.scl_level, m_scl_level);
                    check_field("sda_released", want.sda_released, m_sda_released);
                    check_field("busy_res", want.busy, m_busy_res);
                    check_field("done_res", want.done, m_done_res);
                    check_field("received_byte", want.received_byte, m_received_byte);
                    check_field("ack_seen", want.ack_seen, m_ack_seen);
                    check_field("rejected", want.rejected, m_rejected);
                end
            end
            if (stall_left == 0 && $urandom_range(99) < sink_stall_pct) begin
                stall_left = idle_length();
            end
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Stimulus and end of run.
    initial begin : stimulus
        logic [7:0] hp_plan [6];
        int         target;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part at the reset half period of ten ticks: ticks and an
        // undefined code while idle, then a start during which a write is
        // refused and a word arrives without a tick.
        queue_word(ibms_pkg::CMD_TICK, 8'h00, 1'b0, 1'b0, 1'b1);
        queue_word(CMD_UNUSED_LAST, 8'hFF, 1'b1, 1'b1, 1'b1);
        starts_sent++;
        queue_word(ibms_pkg::CMD_START, 8'h00, 1'b0, 1'b1, 1'b1);
        queue_word(ibms_pkg::CMD_WRITE, 8'hFF, 1'b1, 1'b1, 1'b0);
        queue_word(CMD_UNUSED_FIRST, 8'h00, 1'b0, 1'b0, 1'b1);
        finish_busy(-1, 1'b0);

        // A zero half period must behave like one tick. Cover both data
        // extremes, ACK and NACK on both sides, a repeated start from SDA held
        // low after an acknowledged read, and a stop after a stop.
        set_half_period(8'd0);
        issue_command(ibms_pkg::CMD_WRITE, 8'h00, 1'b0, 1, 1'b0);
        issue_command(ibms_pkg::CMD_READ, 8'h00, 1'b1, 1, 1'b0);
        issue_command(ibms_pkg::CMD_START, 8'h00, 1'b0, -1, 1'b0);
        issue_command(ibms_pkg::CMD_WRITE, 8'hFF, 1'b0, 0, 1'b0);
        issue_command(ibms_pkg::CMD_READ, 8'hFF, 1'b0, 0, 1'b0);
        issue_command(ibms_pkg::CMD_STOP, 8'h00, 1'b0, -1, 1'b0);
        issue_command(ibms_pkg::CMD_STOP, 8'h00, 1'b0, -1, 1'b0);

        // Random transactions over several small settings.
        hp_plan = '{8'd1, 8'd3, 8'd2, 8'($urandom_range(6, 4)), 8'd0, 8'd1};
        foreach (hp_plan[i]) begin
            set_half_period(hp_plan[i]);
            target = busy_words + PHASE_WORDS;
            while (busy_words < target) begin
                run_transaction();
            end
            if (i == 2) begin
                // The largest half period, where the divider also saturates;
                // one start sequence is enough to walk through it.
                set_half_period(8'hFF);
                issue_command(ibms_pkg::CMD_START, 8'($urandom_range(255)), 1'b0, -1, 1'b0);
            end
        end

        while (cmd_words_pending.size() != 0 || line_states_due.size() != 0) begin
            @(posedge aclk);
        end
        repeat (10) @(posedge aclk);

        $display("Checked %0d command words over %0d half-period settings, 0, 1 and 255 included.",
                 words_accepted, settings_made);
        $display("Sent %0d starts, %0d stops, %0d writes and %0d reads; %0d commands refused.",
                 starts_sent, stops_sent, writes_sent, reads_sent, refused_count);
        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin : watchdog
        #20_000_000;
        $display("Run did not finish in time, %0d result words still due",
                 line_states_due.size());
        $display("FAILURE");
        $finish;
    end

endmodule
